// ===== rtl/tdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tdf_pkg: shared types and constants of the trial division factorizer
// Status codes of a result item and the first trial divisor.
// ----------------------------------------------------------------------------
`default_nettype none

package tdf_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FACTORS = 2'd1,
    ST_INVALID    = 2'd2
  } status_t;

  localparam int FIRST_DIVISOR = 2;

endpackage

`default_nettype wire

// ===== rtl/tdf_front.sv =====
// ----------------------------------------------------------------------------
// tdf_front: input side of the factorizer
// Accepts items, tags zero / one / larger values, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   value_valid,
  output logic                        value_stall,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output logic                        q_valid,
  input  wire logic                   q_pop,
  output logic [VALUE_WIDTH-1:0]      q_value,
  output tdf_pkg::status_t            q_status
);

  logic [VALUE_WIDTH-1:0] val_mem [2];
  tdf_pkg::status_t       st_mem  [2];
  logic                   wp;
  logic                   rp;
  logic [1:0]             cnt;
  logic                   push;
  tdf_pkg::status_t       cls;

  always_comb begin
    if (value == '0) begin
      cls = tdf_pkg::ST_INVALID;
    end else if (value == VALUE_WIDTH'(1)) begin
      cls = tdf_pkg::ST_NO_FACTORS;
    end else begin
      cls = tdf_pkg::ST_OK;
    end
  end

  assign value_stall = (cnt == 2'd2);
  assign push        = value_valid && !value_stall;
  assign q_valid     = (cnt != 2'd0);
  assign q_value     = val_mem[rp];
  assign q_status    = st_mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      val_mem[wp] <= value;
      st_mem[wp]  <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> cnt != 2'd0)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== rtl/tdf_div.sv =====
// ----------------------------------------------------------------------------
// tdf_div: serial divider
// Restoring division, one quotient bit per cycle; results hold after done.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [VALUE_WIDTH-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [VALUE_WIDTH-1:0]      quotient,
  output logic [VALUE_WIDTH-1:0]      remainder
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [CW-1:0]          cnt;
  logic [VALUE_WIDTH:0]   trial;

  assign trial     = {acc, quo[VALUE_WIDTH-1]} - {1'b0, dvs};
  assign quotient  = quo;
  assign remainder = acc;

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
      dvs <= divisor;
      cnt <= CW'(VALUE_WIDTH);
    end else if (busy) begin
      if (trial[VALUE_WIDTH]) begin
        acc <= {acc[VALUE_WIDTH-2:0], quo[VALUE_WIDTH-1]};
      end else begin
        acc <= trial[VALUE_WIDTH-1:0];
      end
      quo <= {quo[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tdf_back.sv =====
// ----------------------------------------------------------------------------
// tdf_back: trial division engine
// Steps the divisor from 2, divides the cofactor by it with the serial
// divider, and sends each prime with its exponent through the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tdf_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  output logic                        q_pop,
  input  wire logic [VALUE_WIDTH-1:0] q_value,
  input  wire tdf_pkg::status_t       q_status,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [VALUE_WIDTH-1:0]      prime,
  output logic [4:0]                  multiplicity,
  output logic [3:0]                  factor_index,
  output logic                        last,
  output logic [1:0]                  status
);

  localparam int MULT_W = ($clog2(VALUE_WIDTH) > 5) ? $clog2(VALUE_WIDTH) : 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DECIDE,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] d;
  logic [MULT_W-1:0]      mult;
  logic [3:0]             idx;
  logic                   pend_v;
  logic [VALUE_WIDTH-1:0] pend_prime;
  logic [MULT_W-1:0]      pend_mult;
  logic [MULT_W-1:0]      out_mult;
  tdf_pkg::status_t       out_status;
  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] rmd;
  logic                   out_free;
  logic                   rem_gt1;

  tdf_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rem),
    .divisor   (d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rmd)
  );

  assign out_free     = !result_valid || !result_stall;
  assign q_pop        = (state == S_IDLE) && q_valid && out_free;
  assign rem_gt1      = |rem[VALUE_WIDTH-1:1];
  assign multiplicity = out_mult[4:0];
  assign status       = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      div_start    <= 1'b0;
      pend_v       <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_status != tdf_pkg::ST_OK) begin
              result_valid <= 1'b1;
              prime        <= '0;
              out_mult     <= '0;
              factor_index <= 4'd0;
              last         <= 1'b1;
              out_status   <= q_status;
            end else begin
              rem       <= q_value;
              d         <= VALUE_WIDTH'(tdf_pkg::FIRST_DIVISOR);
              mult      <= '0;
              idx       <= 4'd0;
              pend_v    <= 1'b0;
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (mult == '0 && d > quo) begin
            state <= S_FINISH;
          end else if (rmd == '0) begin
            rem       <= quo;
            mult      <= mult + MULT_W'(1);
            div_start <= 1'b1;
            state     <= S_DIV;
          end else if (!(mult != '0 && pend_v && !out_free)) begin
            if (mult != '0) begin
              if (pend_v) begin
                result_valid <= 1'b1;
                prime        <= pend_prime;
                out_mult     <= pend_mult;
                factor_index <= idx;
                last         <= 1'b0;
                out_status   <= tdf_pkg::ST_OK;
                idx          <= idx + 4'd1;
              end
              pend_prime <= d;
              pend_mult  <= mult;
              pend_v     <= 1'b1;
            end
            d         <= d + VALUE_WIDTH'(1);
            mult      <= '0;
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            factor_index <= idx;
            out_status   <= tdf_pkg::ST_OK;
            idx          <= idx + 4'd1;
            if (pend_v) begin
              prime    <= pend_prime;
              out_mult <= pend_mult;
              last     <= !rem_gt1;
              pend_v   <= 1'b0;
              if (!rem_gt1) begin
                state <= S_IDLE;
              end
            end else begin
              prime    <= rem;
              out_mult <= MULT_W'(1);
              last     <= 1'b1;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_nonok_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_status != tdf_pkg::ST_OK |-> last && prime == '0)
    else $error("status item with factor data");

  a_divisor_min: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV || state == S_DECIDE |-> d >= VALUE_WIDTH'(tdf_pkg::FIRST_DIVISOR))
    else $error("trial divisor below first divisor");

  a_pend_prime: assert property (@(posedge clk) disable iff (rst)
    pend_v && state == S_DECIDE |-> pend_prime < d && pend_mult != '0)
    else $error("pending factor out of order");

endmodule

`default_nettype wire

// ===== rtl/trial_division_factorizer.sv =====
// ----------------------------------------------------------------------------
// trial_division_factorizer: prime factorization by trial division
// Inputs 0 and 1 give their single item through the queue and result register.
// Otherwise each trial division runs divider start, VALUE_WIDTH divider steps,
// done and decision, with one division per divisor tried plus one per prime
// power found; a prime near 2^VALUE_WIDTH needs about 2^(VALUE_WIDTH/2) of them.
// One item is worked at a time; a two-entry queue takes the next ones early.
// Reset: synchronous, clears queue, engine state and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_factorizer #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   value_valid,
  output logic                        value_stall,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [VALUE_WIDTH-1:0]      prime,
  output logic [4:0]                  multiplicity,
  output logic [3:0]                  factor_index,
  output logic                        last,
  output logic [1:0]                  status
);

  logic                   q_valid;
  logic                   q_pop;
  logic [VALUE_WIDTH-1:0] q_value;
  tdf_pkg::status_t       q_status;

  tdf_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_value     (q_value),
    .q_status    (q_status)
  );

  tdf_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_value      (q_value),
    .q_status     (q_status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .prime        (prime),
    .multiplicity (multiplicity),
    .factor_index (factor_index),
    .last         (last),
    .status       (status)
  );

endmodule

`default_nettype wire
